### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/boe_pkg.sv
// Package for the BER object identifier encoder: request/result types,
// microcode word and step types, control ROM and digit helpers. No dependencies.
`timescale 1ns / 1ps

package boe_pkg;

  localparam int MAX_SUBIDS = 12;
  localparam int IDX_W      = $clog2(MAX_SUBIDS);
  localparam int CNT_W      = $clog2(MAX_SUBIDS + 1);
  localparam int MAX_DIGITS = 5;
  localparam int POS_W      = 3;
  localparam int LEN_W      = $clog2(MAX_SUBIDS * MAX_DIGITS + 1);
  localparam int DIGIT_BITS = 7;
  localparam logic [7:0] MORE_BIT   = 8'h80;
  localparam logic [6:0] DIGIT_MASK = 7'h7F;

  typedef struct packed {
    logic [31:0] subid;
    logic [7:0]  tag;
    logic        is_last;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       overflow;
  } result_t;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_SUM,
    STEP_TAG,
    STEP_LEN,
    STEP_DIGIT
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_LAST_REQ,
    COND_MORE_SUBIDS,
    COND_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    logic  take_req;
    logic  sum_en;
    logic  emit_tag;
    logic  emit_len;
    logic  emit_digit;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } ctrl_t;

  // Control program: one word per step.
  function automatic ctrl_t rom_word(step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      STEP_IDLE: begin
        w.take_req = 1'b1;
        w.cond     = COND_LAST_REQ;
        w.on_true  = STEP_SUM;
        w.on_false = STEP_IDLE;
      end
      STEP_SUM: begin
        w.sum_en   = 1'b1;
        w.cond     = COND_MORE_SUBIDS;
        w.on_true  = STEP_SUM;
        w.on_false = STEP_TAG;
      end
      STEP_TAG: begin
        w.emit_tag = 1'b1;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_LEN;
        w.on_false = STEP_LEN;
      end
      STEP_LEN: begin
        w.emit_len = 1'b1;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_DIGIT;
        w.on_false = STEP_DIGIT;
      end
      STEP_DIGIT: begin
        w.emit_digit = 1'b1;
        w.cond       = COND_MORE_DIGITS;
        w.on_true    = STEP_DIGIT;
        w.on_false   = STEP_IDLE;
      end
      default: begin
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_IDLE;
        w.on_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Minimal number of base-128 digits of a value.
  function automatic logic [POS_W-1:0] digit_count(logic [31:0] v);
    logic [POS_W-1:0] n;
    if (v[31:28] != '0)      n = POS_W'(5);
    else if (v[27:21] != '0) n = POS_W'(4);
    else if (v[20:14] != '0) n = POS_W'(3);
    else if (v[13:7] != '0)  n = POS_W'(2);
    else                     n = POS_W'(1);
    return n;
  endfunction

  // Base-128 digit at a position, zero being the least significant.
  function automatic logic [6:0] digit_at(logic [31:0] v, logic [POS_W-1:0] p);
    logic [6:0] d;
    case (p)
      POS_W'(0): d = v[6:0];
      POS_W'(1): d = v[13:7];
      POS_W'(2): d = v[20:14];
      POS_W'(3): d = v[27:21];
      default:   d = {3'b000, v[31:28]};
    endcase
    return d & DIGIT_MASK;
  endfunction

endpackage

### hdl/ber_oid_encoder.sv
// Top level of the BER object identifier encoder: a microcoded sequencer
// over a small subidentifier store. Depends on boe_pkg.
//
//   channel   ports                      handshake
//   request   start, busy, request       taken when start && !busy
//   result    strobe, result             one octet per cycle, no stall
//
// A request that is not last only loads the store. A last request is
// loaded, then the length sum steps once per stored subidentifier, then
// the tag and length octets go out, then the content octets at one per
// cycle from the digit step. Results leave through an output register,
// in the cycle after their step. Reset empties the store count and
// clears the overflow flag; the receiver cannot stall the result stream.
`timescale 1ns / 1ps

module ber_oid_encoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  boe_pkg::req_t    request,
  output logic             strobe,
  output boe_pkg::result_t result
);
  import boe_pkg::*;

  logic [31:0]      store [MAX_SUBIDS];
  logic [CNT_W-1:0] count;
  logic             dropped;
  step_t            step;
  step_t            step_next;
  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] total;
  logic [7:0]       tag;

  ctrl_t            ctrl;
  logic             accept;
  logic [31:0]      cur;
  logic [POS_W-1:0] dc;
  logic [IDX_W-1:0] idx_inc;
  logic             more_sub;
  logic             last_digit;
  logic             emit;
  result_t          emit_res;

  // Decode the current control word and common datapath terms
  assign ctrl       = rom_word(step);
  assign busy       = (step != STEP_IDLE);
  assign accept     = ctrl.take_req && start;
  assign cur        = store[idx];
  assign dc         = digit_count(cur);
  assign idx_inc    = idx + 1'b1;
  assign more_sub   = ({1'b0, idx_inc} < {{(IDX_W + 1 - CNT_W){1'b0}}, count});
  assign last_digit = (pos == dc - 1'b1);

  // Next step: evaluate the jump condition of the control word
  always_comb begin
    logic c;
    c = 1'b0;
    unique case (ctrl.cond)
      COND_ALWAYS:      c = 1'b1;
      COND_LAST_REQ:    c = accept && request.is_last;
      COND_MORE_SUBIDS: c = more_sub;
      COND_MORE_DIGITS: c = !(last_digit && !more_sub);
      default:          c = 1'b0;
    endcase
    step_next = c ? ctrl.on_true : ctrl.on_false;
  end

  // Output octet selection for the current step
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    emit_res.overflow = dropped;
    if (ctrl.emit_tag) begin
      emit              = 1'b1;
      emit_res.out_byte = tag;
    end else if (ctrl.emit_len) begin
      emit              = 1'b1;
      emit_res.out_byte = 8'(total);
    end else if (ctrl.emit_digit) begin
      emit              = 1'b1;
      emit_res.out_byte = {1'b0, digit_at(cur, dc - 1'b1 - pos)}
                          | (last_digit ? 8'h00 : MORE_BIT);
      emit_res.end_of_run = last_digit && !more_sub;
    end
  end

  // Advance the step counter and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      step   <= step_next;
      strobe <= emit;
      if (accept) begin
        if (count < CNT_W'(MAX_SUBIDS)) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      // Empty the store after the final octet
      if (ctrl.emit_digit && last_digit && !more_sub) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // Register the result, hold the tag, store subidentifiers, sum the length and run the index and digit counters
  always_ff @(posedge clk) begin
    result <= emit_res;
    if (accept && count < CNT_W'(MAX_SUBIDS)) begin
      store[count[IDX_W-1:0]] <= request.subid;
    end
    if (accept) begin
      tag   <= request.tag;
      idx   <= '0;
      pos   <= '0;
      total <= '0;
    end
    if (ctrl.sum_en) begin
      total <= total + LEN_W'(dc);
      idx   <= more_sub ? idx_inc : '0;
    end
    if (ctrl.emit_digit) begin
      if (last_digit) begin
        pos <= '0;
        idx <= idx_inc;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

### hdl/boe_checker.sv
// Port-level checker for the BER object identifier encoder, bound to the
// top level. Depends on boe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module boe_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input boe_pkg::req_t    request,
  input logic             strobe,
  input boe_pkg::result_t result
);
  import boe_pkg::*;

  // Octets only come out of a run that was busy the cycle before
  `ASSERT_IMPL(a_strobe_after_busy, clk, rst, strobe, $past(busy))
  // The final octet closes the stream
  `ASSERT_NEXT(a_end_closes, clk, rst, strobe && result.end_of_run, !strobe)
  // A last request starts a run
  `ASSERT_NEXT(a_last_starts, clk, rst, start && !busy && request.is_last, busy)
  // A request that is not last only loads the store
  `ASSERT_NEXT(a_load_only, clk, rst, start && !busy && !request.is_last, !busy && !strobe)

endmodule

bind ber_oid_encoder boe_checker u_boe_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);
